FILE: hw/rtl/mltfd_pkg.sv
// Shared types and constants of the MAC learning table with flap detection.
`default_nettype none
package mltfd_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = IDX_W + 1;

   localparam logic [31:0] FLAP_WINDOW_RESET = 32'd1000;
   localparam logic [7:0]  FLAP_LIMIT_RESET  = 8'd3;
   localparam logic [7:0]  FLAPS_MAX         = 8'hFF;

   typedef enum logic {
      OP_ADD    = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_ADDED     = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_FLAPPING  = 3'd2,
      ST_IGNORED   = 3'd3,
      ST_DELETED   = 3'd4,
      ST_NOT_FOUND = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   typedef enum logic {
      CSR_FLAP_WINDOW = 1'b0,
      CSR_FLAP_LIMIT  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_SCAN = 2'd1,
      FSM_EXEC = 2'd2
   } fsm_state_type;

   typedef struct packed {
      logic        operation;
      logic [47:0] station_mac;
      logic [31:0] endpoint_ip;
      logic [47:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] flap_total;
      logic       entry_unstable;
   } rsp_type;

   typedef struct packed {
      logic [47:0] mac;
      logic [31:0] current_endpoint;
      logic [31:0] previous_endpoint;
      logic [47:0] last_seen;
      logic [7:0]  flaps;
      logic        unstable;
   } entry_type;

   typedef struct packed {
      logic load;
      logic step;
      logic exec;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } ctl_status_type;

endpackage
`default_nettype wire

FILE: hw/rtl/mltfd_datapath.sv
// Datapath: request latch, entry memory, slot scan, flap update and result register.
`default_nettype none
module mltfd_datapath (
   input  wire                          clock,
   input  wire                          reset,
   input  mltfd_pkg::ctl_cmd_type       cmd,
   output mltfd_pkg::ctl_status_type    status,
   input  mltfd_pkg::req_type           req_data,
   output mltfd_pkg::rsp_type           rsp_data,
   input  wire                          csr_valid,
   input  mltfd_pkg::csr_index_type     csr_index,
   input  wire [31:0]                   csr_data
);
   import mltfd_pkg::*;

   req_type                  req_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     cmp_act_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   entry_type                mem [TABLE_ENTRIES];
   entry_type                rd_data_ff;
   logic                     rd_valid_ff;
   logic [IDX_W-1:0]         rd_idx_ff;
   logic                     hit_ff;
   logic [IDX_W-1:0]         hit_idx_ff;
   entry_type                hit_data_ff;
   logic                     free_ff;
   logic [IDX_W-1:0]         free_idx_ff;
   logic [31:0]              window_ff;
   logic [7:0]               limit_ff;
   rsp_type                  rsp_ff;

   logic             issue;
   logic [IDX_W-1:0] rd_addr;
   logic             cmp_en;
   logic             hit_now;
   logic [47:0]      gap;
   logic             in_window;
   logic [7:0]       flaps_next;
   logic             over_limit;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_data;
   logic             valid_set;
   logic             valid_clr;
   rsp_type          rsp_in;

   assign rd_addr = cnt_ff[IDX_W-1:0];
   assign issue   = cmd.step && (cnt_ff != CNT_W'(TABLE_ENTRIES));
   assign cmp_en  = cmp_act_ff && cmd.step;
   assign hit_now = rd_valid_ff && (rd_data_ff.mac == req_ff.station_mac);
   assign status.scan_done = cmp_en && (hit_now || (rd_idx_ff == IDX_W'(TABLE_ENTRIES - 1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         cmp_act_ff <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
         valid_ff   <= '0;
         window_ff  <= FLAP_WINDOW_RESET;
         limit_ff   <= FLAP_LIMIT_RESET;
      end else begin
         if (cmd.load) begin
            cnt_ff     <= '0;
            cmp_act_ff <= 1'b0;
            hit_ff     <= 1'b0;
            free_ff    <= 1'b0;
         end else begin
            cmp_act_ff <= issue;
            if (issue) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
            if (cmp_en && hit_now) begin
               hit_ff <= 1'b1;
            end
            if (cmp_en && !rd_valid_ff && !free_ff) begin
               free_ff <= 1'b1;
            end
         end
         if (cmd.exec && valid_set) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (cmd.exec && valid_clr) begin
            valid_ff[hit_idx_ff] <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_FLAP_WINDOW: window_ff <= csr_data;
               CSR_FLAP_LIMIT:  limit_ff  <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (issue) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_idx_ff   <= rd_addr;
      end
      if (cmp_en && hit_now) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_data_ff <= rd_data_ff;
      end
      if (cmp_en && !rd_valid_ff && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   assign gap        = req_ff.time_ms - hit_data_ff.last_seen;
   assign in_window  = (req_ff.time_ms < hit_data_ff.last_seen) || (gap < {16'd0, window_ff});
   assign over_limit = flaps_next > limit_ff;

   always_comb begin
      if (!in_window) begin
         flaps_next = '0;
      end else if (hit_data_ff.flaps == FLAPS_MAX) begin
         flaps_next = hit_data_ff.flaps;
      end else begin
         flaps_next = 8'(hit_data_ff.flaps + 8'd1);
      end
   end

   always_comb begin
      wr_en                 = 1'b0;
      wr_idx                = hit_idx_ff;
      wr_data               = hit_data_ff;
      valid_set             = 1'b0;
      valid_clr             = 1'b0;
      rsp_in.status         = ST_FULL;
      rsp_in.flap_total     = '0;
      rsp_in.entry_unstable = 1'b0;
      if (req_ff.operation == OP_DELETE) begin
         if (hit_ff) begin
            valid_clr     = 1'b1;
            rsp_in.status = ST_DELETED;
         end else begin
            rsp_in.status = ST_NOT_FOUND;
         end
      end else if (!hit_ff) begin
         if (free_ff) begin
            wr_en                     = 1'b1;
            valid_set                 = 1'b1;
            wr_idx                    = free_idx_ff;
            wr_data.mac               = req_ff.station_mac;
            wr_data.current_endpoint  = req_ff.endpoint_ip;
            wr_data.previous_endpoint = '0;
            wr_data.last_seen         = req_ff.time_ms;
            wr_data.flaps             = '0;
            wr_data.unstable          = 1'b0;
            rsp_in.status             = ST_ADDED;
         end else begin
            rsp_in.status = ST_FULL;
         end
      end else if (hit_data_ff.current_endpoint == req_ff.endpoint_ip) begin
         rsp_in.status         = ST_IGNORED;
         rsp_in.flap_total     = hit_data_ff.flaps;
         rsp_in.entry_unstable = hit_data_ff.unstable;
      end else begin
         wr_en                     = 1'b1;
         wr_data.previous_endpoint = hit_data_ff.current_endpoint;
         wr_data.current_endpoint  = req_ff.endpoint_ip;
         wr_data.last_seen         = req_ff.time_ms;
         wr_data.flaps             = flaps_next;
         wr_data.unstable          = hit_data_ff.unstable || over_limit;
         rsp_in.status             = over_limit ? ST_FLAPPING : ST_UPDATED;
         rsp_in.flap_total         = flaps_next;
         rsp_in.entry_unstable     = hit_data_ff.unstable || over_limit;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/mltfd_controller.sv
// Controller: sequences accept, slot scan and write-back, and owns the result valid flag.
`default_nettype none
module mltfd_controller (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output mltfd_pkg::ctl_cmd_type       cmd,
   input  mltfd_pkg::ctl_status_type    status
);
   import mltfd_pkg::*;

   fsm_state_type state_ff;
   fsm_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_done) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.exec = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/mac_learning_table_flap_detect_unit.sv
// Top level of the MAC learning table with flap detection.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data  (mltfd_pkg::req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (mltfd_pkg::rsp_type)
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One request at a time; the slot scan goes through the single read port of the entry memory,
// one slot per cycle, and ends at the first matching slot or at the last slot.
// Reset clears all slot valid bits at once and loads the register defaults; no clearing pass.
// The result waits in an output register; the next request is taken while it waits, and
// write-back holds only while an earlier result is still not taken.
// Configuration writes are always taken.
`default_nettype none
module mac_learning_table_flap_detect_unit (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  mltfd_pkg::req_type        req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output mltfd_pkg::rsp_type        rsp_data,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  mltfd_pkg::csr_index_type  csr_index,
   input  wire [31:0]                csr_data
);
   import mltfd_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   assign csr_ready = 1'b1;

   mltfd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   mltfd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a request is in progress");

   a_exec_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("write-back without a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
